### src/rlpm_pkg.sv
// shared types, constants and helpers for the longest-prefix-match route table
// no dependencies
package rlpm_pkg;

   // table size and derived widths
   localparam int ROUTE_ENTRIES = 16;
   localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

   // field widths
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int EIDX_W  = 4;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 40;

   // request kinds carried on tuser
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one stored route, prefix length worked out at write time
   typedef struct packed {
      logic [ADDR_W-1:0] gateway;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] dest;
      logic [LEN_W-1:0]  len;
   } route_entry_type;

   localparam int ENTRY_W = $bits(route_entry_type);

   // count of leading one bits: position of the highest zero bit wins
   function automatic logic [LEN_W-1:0] leading_ones(input logic [ADDR_W-1:0] m);
      logic [LEN_W-1:0] n;
      n = LEN_W'(ADDR_W);
      for (int i = 0; i < ADDR_W; i++) begin
         if (!m[i]) begin
            n = LEN_W'(ADDR_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

### src/rlpm_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module rlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/route_longest_prefix_match.sv
// IPv4 longest-prefix-match route table: controller, valid bits and result register
// depends on rlpm_pkg and rlpm_ram
//
// Usage:
//   req channel: each word is a route write (tuser = 0) or a lookup (tuser = 1).
//   A route write stores destination, mask, gateway and valid at entry_index and
//   returns nothing; it is taken in ST_IDLE and the next word may follow at once.
//   A lookup walks the route ram one entry per cycle from entry 0 upward,
//   comparing (address & mask) against destination and keeping the longest
//   prefix; the lowest index wins a tie, and a /0 route can win.
//   rsp channel: one word per lookup with next hop and prefix length in tdata
//   and the found flag in tuser; no match gives next hop 0, found 0, length 0.
// Timing:
//   a lookup holds req_tready low while in ST_SCAN and ST_DONE, as the single
//   read port of the route ram gives one entry at a time; the result register
//   is loaded as ST_DONE returns to ST_IDLE.
// Reset: synchronous, clears all valid bits and the result valid flag; ram
//   contents are left as they are and count only while their valid bit is set.
// Stall: a waiting result sits in the output register while new words are
//   taken; a finished lookup waits in its last state until that register frees.
module route_longest_prefix_match
   import rlpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[3:0], route_dest[35:4], route_mask[67:36],
   // route_gateway[99:68], route_valid[100], lookup_addr[132:101], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[0]
   input  logic                  req_tuser,
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_hop[31:0], prefix_len[37:32], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // found[0]
   output logic                  rsp_tuser
);

   // request field unpacking
   logic [EIDX_W-1:0] entry_index;
   logic [ADDR_W-1:0] route_dest;
   logic [ADDR_W-1:0] route_mask;
   logic [ADDR_W-1:0] route_gateway;
   logic              route_valid;
   logic [ADDR_W-1:0] lookup_addr;

   assign entry_index   = req_tdata[3:0];
   assign route_dest    = req_tdata[35:4];
   assign route_mask    = req_tdata[67:36];
   assign route_gateway = req_tdata[99:68];
   assign route_valid   = req_tdata[100];
   assign lookup_addr   = req_tdata[132:101];

   // control state
   state_type state_ff, state_in;
   logic [CNT_W-1:0]         rd_cnt_ff;
   logic                     cmp_vld_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;
   logic [ROUTE_ENTRIES-1:0] valid_ff;

   // lookup working registers
   logic [ADDR_W-1:0] addr_ff;
   logic              hit_ff;
   logic [LEN_W-1:0]  best_len_ff;
   logic [ADDR_W-1:0] best_gw_ff;

   // result register
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_hop_ff;
   logic              rsp_found_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic accept;
   logic wr_go;
   logic lk_go;
   logic rd_issue;
   logic scan_last;
   logic rsp_load;
   logic rsp_free;

   route_entry_type wr_entry;
   route_entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic [IDX_W-1:0]   wr_addr;
   logic               entry_match;

   assign accept = req_tvalid && req_tready;
   assign wr_go  = accept && (req_tuser == FUNC_WRITE)
                   && (int'(entry_index) < ROUTE_ENTRIES);
   assign lk_go  = accept && (req_tuser == FUNC_LOOKUP);
   assign wr_addr = IDX_W'(entry_index);

   // route word built on the way in
   always_comb begin
      wr_entry.gateway = route_gateway;
      wr_entry.mask    = route_mask;
      wr_entry.dest    = route_dest;
      wr_entry.len     = leading_ones(route_mask);
   end

   // route storage
   rlpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROUTE_ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_go),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = route_entry_type'(rd_word);

   // scan progress
   assign rd_issue  = (state_ff == ST_SCAN) && (int'(rd_cnt_ff) < ROUTE_ENTRIES);
   assign scan_last = cmp_vld_ff && (cmp_idx_ff == IDX_W'(ROUTE_ENTRIES - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // entry compare against the word just read
   assign entry_match = cmp_vld_ff && valid_ff[cmp_idx_ff]
                        && ((addr_ff & rd_entry.mask) == rd_entry.dest);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (lk_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read counter and compare pipeline tag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         cmp_idx_ff <= '0;
      end else begin
         cmp_vld_ff <= rd_issue;
         cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
         if (lk_go) begin
            rd_cnt_ff <= '0;
         end else if (rd_issue) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_go) begin
         valid_ff[wr_addr] <= route_valid;
      end
   end

   // best match so far
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (lk_go) begin
         hit_ff <= 1'b0;
      end else if (entry_match) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_go) begin
         addr_ff     <= lookup_addr;
         best_len_ff <= '0;
         best_gw_ff  <= '0;
      end else if (entry_match && (!hit_ff || (rd_entry.len > best_len_ff))) begin
         best_len_ff <= rd_entry.len;
         best_gw_ff  <= rd_entry.gateway;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hop_ff   <= best_gw_ff;
         rsp_found_ff <= hit_ff;
         rsp_len_ff   <= best_len_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - LEN_W){1'b0}}, rsp_len_ff, rsp_hop_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

### bench/tb_route_longest_prefix_match.sv
// self-checking bench for the longest-prefix-match route table: directed rows, then random
// route writes and lookups under three idling phases and one long output stall
// depends on rlpm_pkg and route_longest_prefix_match
module tb_route_longest_prefix_match
   import rlpm_pkg::*;
();

   localparam int RANDOM_PER_PHASE = 210;
   localparam int POOL_SIZE        = 4;
   localparam int LONG_STALL       = 300;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REQ_PAD_W        = REQ_DATA_W - (EIDX_W + 4 * ADDR_W + 1);

   // one request word in field form
   typedef struct packed {
      logic              func;
      logic [EIDX_W-1:0] slot;
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic              valid;
      logic [ADDR_W-1:0] addr;
   } route_req_type;

   // one lookup answer in field form
   typedef struct packed {
      logic [ADDR_W-1:0] next_hop;
      logic              found;
      logic [LEN_W-1:0]  prefix_len;
   } lookup_result_type;

   // directed row: request plus an optional hand-written answer
   typedef struct packed {
      route_req_type     item;
      logic              typed;
      lookup_result_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // shadow copy of the route table
   logic [ADDR_W-1:0] shadow_dest  [ROUTE_ENTRIES];
   logic [ADDR_W-1:0] shadow_mask  [ROUTE_ENTRIES];
   logic [ADDR_W-1:0] shadow_gw    [ROUTE_ENTRIES];
   logic              shadow_valid [ROUTE_ENTRIES];

   lookup_result_type pending_results[$];
   lookup_result_type rsp_want;
   directed_row_type  directed_rows[$];
   logic [ADDR_W-1:0] net_pool[POOL_SIZE];

   int  send_idle_pct = 10;
   int  recv_idle_pct = 68;
   logic hold_off = 1'b0;
   logic pressure_go = 1'b0;
   int  errors = 0;
   int  cycle_count = 0;
   int  route_writes = 0;
   int  lookups = 0;
   int  hits = 0;
   int  default_wins = 0;

   route_longest_prefix_match uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // leading run of ones in a mask
   function automatic logic [LEN_W-1:0] count_prefix(input logic [ADDR_W-1:0] m);
      logic [LEN_W-1:0] n;
      n = '0;
      while (n < ADDR_W && m[ADDR_W-1]) begin
         m = m << 1;
         n++;
      end
      return n;
   endfunction

   // scan from slot 0 up, a later slot wins only with a strictly longer prefix
   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] a);
      lookup_result_type r;
      logic [LEN_W-1:0] len;
      r = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         if (shadow_valid[i] && (a & shadow_mask[i]) == shadow_dest[i]) begin
            len = count_prefix(shadow_mask[i]);
            if (!r.found || len > r.prefix_len) begin
               r.found = 1'b1;
               r.prefix_len = len;
               r.next_hop = shadow_gw[i];
            end
         end
      end
      return r;
   endfunction

   // request with every field random, so unused fields still toggle
   function automatic route_req_type noise_item(input logic func);
      route_req_type it;
      it.func = func;
      it.slot = EIDX_W'($urandom_range(ROUTE_ENTRIES - 1));
      it.dest = $urandom();
      it.mask = $urandom();
      it.gateway = $urandom();
      it.valid = 1'($urandom_range(1));
      it.addr = $urandom();
      return it;
   endfunction

   // directed table entries
   function automatic void put_route(input int slot, input logic [ADDR_W-1:0] dest,
                                     input logic [ADDR_W-1:0] mask,
                                     input logic [ADDR_W-1:0] gw, input logic valid);
      directed_row_type row;
      row = '0;
      row.item = noise_item(FUNC_WRITE);
      row.item.slot = EIDX_W'(slot);
      row.item.dest = dest;
      row.item.mask = mask;
      row.item.gateway = gw;
      row.item.valid = valid;
      directed_rows.push_back(row);
   endfunction

   function automatic void ask_route(input logic [ADDR_W-1:0] addr, input logic typed,
                                     input logic [ADDR_W-1:0] hop, input logic found,
                                     input int len);
      directed_row_type row;
      row.item = noise_item(FUNC_LOOKUP);
      row.item.addr = addr;
      row.typed = typed;
      row.want.next_hop = hop;
      row.want.found = found;
      row.want.prefix_len = LEN_W'(len);
      directed_rows.push_back(row);
   endfunction

   // random word: mostly well-formed routes around a few shared networks
   function automatic route_req_type random_item();
      route_req_type it;
      int pick;
      int len;
      int k;
      it = noise_item(($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_LOOKUP);
      pick = $urandom_range(99);
      if (it.func == FUNC_WRITE) begin
         len = (pick < 10) ? ADDR_W : (pick < 18) ? 0 : $urandom_range(ADDR_W - 1, 1);
         // a few masks stay fully random, gaps and all
         if ($urandom_range(99) >= 12) begin
            it.mask = (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
         end
         pick = $urandom_range(99);
         if (pick < 80) begin
            it.dest = net_pool[$urandom_range(POOL_SIZE - 1)] & it.mask;
         end else if (pick < 90) begin
            it.dest = it.dest & it.mask;
         end
         it.valid = ($urandom_range(99) < 85);
      end else begin
         if (pick < 55) begin
            it.addr = net_pool[$urandom_range(POOL_SIZE - 1)]
                      ^ (ADDR_W'($urandom()) >> $urandom_range(ADDR_W));
         end else if (pick < 80) begin
            k = $urandom_range(ROUTE_ENTRIES - 1);
            it.addr = (shadow_dest[k] & shadow_mask[k]) | (it.addr & ~shadow_mask[k]);
         end else if (pick < 85) begin
            it.addr = '0;
         end else if (pick < 90) begin
            it.addr = '1;
         end
      end
      return it;
   endfunction

   // offer one word, wait for the handshake, then record what it should cause
   task automatic offer_word(input route_req_type it, input logic typed,
                             input lookup_result_type want);
      int gap;
      lookup_result_type got;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.func;
      req_tdata <= {{REQ_PAD_W{1'b0}}, it.addr, it.valid, it.gateway, it.mask, it.dest,
                    it.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (it.func == FUNC_WRITE) begin
         route_writes++;
         if (it.slot < ROUTE_ENTRIES) begin
            shadow_dest[it.slot] = it.dest;
            shadow_mask[it.slot] = it.mask;
            shadow_gw[it.slot] = it.gateway;
            shadow_valid[it.slot] = it.valid;
         end
      end else begin
         got = typed ? want : predict_lookup(it.addr);
         pending_results.push_back(got);
         lookups++;
         if (got.found) hits++;
         if (got.found && got.prefix_len == 0) default_wins++;
      end
   endtask

   // result side: random ready, compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result word: expected none, actual next_hop %h",
                        $time, rsp_tdata[ADDR_W-1:0]);
               errors++;
            end else begin
               rsp_want = pending_results.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== rsp_want.next_hop) begin
                  $display("%0t next_hop: expected %h, actual %h", $time,
                           rsp_want.next_hop, rsp_tdata[ADDR_W-1:0]);
                  errors++;
               end
               if (rsp_tuser !== rsp_want.found) begin
                  $display("%0t found: expected %b, actual %b", $time,
                           rsp_want.found, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[ADDR_W +: LEN_W] !== rsp_want.prefix_len) begin
                  $display("%0t prefix_len: expected %0d, actual %0d", $time,
                           rsp_want.prefix_len, rsp_tdata[ADDR_W +: LEN_W]);
                  errors++;
               end
            end
         end
      end
   end

   // long output hold-off while the sender keeps offering
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      hold_off <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_route_longest_prefix_match: errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
         shadow_dest[i] = '0;
         shadow_mask[i] = '0;
         shadow_gw[i] = '0;
         shadow_valid[i] = 1'b0;
      end

      // empty table
      ask_route(32'h0000_0000, 1'b1, 32'h0, 1'b0, 0);
      ask_route(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 0);
      // default route in the top slot
      put_route(15, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 1'b1);
      ask_route(32'h1234_5678, 1'b1, 32'hC0A8_0001, 1'b1, 0);
      // /8 beats the default
      put_route(0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 1'b1);
      ask_route(32'h0A01_0203, 1'b1, 32'h0A00_00FE, 1'b1, 8);
      // nested /16
      put_route(3, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 1'b1);
      ask_route(32'h0A01_0203, 1'b0, '0, 1'b0, 0);
      // host route, all ones
      put_route(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      ask_route(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32);
      // equal prefix in a higher slot loses to the lower one
      put_route(7, 32'h0A00_0000, 32'hFF00_0000, 32'h1111_1111, 1'b1);
      ask_route(32'h0A7F_0000, 1'b0, '0, 1'b0, 0);
      // mask with a gap: full mask matches, length counts the leading run
      put_route(9, 32'hC000_0001, 32'hFF00_00FF, 32'h2222_2222, 1'b1);
      ask_route(32'hC012_3401, 1'b0, '0, 1'b0, 0);
      // /31
      put_route(10, 32'h5555_5554, 32'hFFFF_FFFE, 32'h3333_3333, 1'b1);
      ask_route(32'h5555_5555, 1'b0, '0, 1'b0, 0);
      // zero-length mask that is not all zeros, ties with the default
      put_route(11, 32'h0000_0000, 32'h7FFF_FFFF, 32'h4444_4444, 1'b1);
      ask_route(32'h8000_0000, 1'b0, '0, 1'b0, 0);
      // write with valid low drops the host route
      put_route(5, $urandom(), $urandom(), $urandom(), 1'b0);
      ask_route(32'hFFFF_FFFF, 1'b0, '0, 1'b0, 0);
      // drop the default, nothing matches
      put_route(15, 32'h0000_0000, 32'h0000_0000, $urandom(), 1'b0);
      ask_route(32'h0102_0304, 1'b1, 32'h0, 1'b0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_word(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // shared networks so that prefixes nest and collide
      net_pool[0] = $urandom();
      net_pool[1] = net_pool[0] ^ (32'h1 << $urandom_range(ADDR_W - 1));
      net_pool[2] = $urandom();
      net_pool[3] = $urandom();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct <= 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct <= 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               pressure_go <= 1'b1;
            end
         endcase
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            offer_word(random_item(), 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let any stray word show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ROUTE_ENTRIES + 4) @(posedge clock);

      $display("run: %0d route writes, %0d lookups, %0d matched",
               route_writes, lookups, hits);
      $display("run: %0d won by a zero-length route, three idling phases, one %0d-cycle hold-off",
               default_wins, LONG_STALL);
      if (errors == 0) begin
         $display("tb_route_longest_prefix_match: clean");
      end else begin
         $display("tb_route_longest_prefix_match: errors");
      end
      $finish;
   end

endmodule

### route_longest_prefix_match.f
src/rlpm_pkg.sv
src/rlpm_ram.sv
src/route_longest_prefix_match.sv
bench/tb_route_longest_prefix_match.sv
